// ===== hw/rtl/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg: shared definitions for the epoch / calendar converter
// Field widths, calendar constants, transaction structures, the shared
// arithmetic unit's request and response, and the calendar helper functions.
// ----------------------------------------------------------------------------
package ucc_pkg;

    // Field widths of one transaction.
    localparam int EpochW = 32;
    localparam int YearW  = 12;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;

    // Packed stream widths, rounded up to whole bytes.
    localparam int FieldBits = EpochW + YearW + MonthW + DayW + HourW + MinW + SecW;
    localparam int TdataW    = ((FieldBits + 7) / 8) * 8;

    // Conversion direction carried in tuser.
    localparam logic MODE_TO_CALENDAR = 1'b0;
    localparam logic MODE_TO_EPOCH    = 1'b1;

    // Calendar constants.
    localparam logic [YearW-1:0]  EPOCH_YEAR    = 12'd1970;
    localparam logic [EpochW-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [EpochW-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [EpochW-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [EpochW-1:0] SECS_PER_COMMON_YEAR = 32'd31536000;
    localparam logic [EpochW-1:0] SECS_PER_LEAP_YEAR   = 32'd31622400;
    localparam logic [8:0]        DAYS_COMMON   = 9'd365;
    localparam logic [8:0]        DAYS_LEAP     = 9'd366;
    localparam logic [4:0]        FEB_COMMON    = 5'd28;
    localparam logic [4:0]        FEB_LEAP      = 5'd29;
    localparam logic [MonthW-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MonthW-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MonthW-1:0] MONTH_DEC     = 4'd12;

    // Days in each month code; codes zero and above twelve count no days.
    localparam logic [15:0][4:0] MONTH_DAYS = {
        5'd0,  5'd0,  5'd0,  5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31, 5'd0
    };

    // One input transaction.
    typedef struct packed {
        logic              mode;
        logic [EpochW-1:0] epoch_seconds;
        logic [YearW-1:0]  calendar_year;
        logic [MonthW-1:0] calendar_month;
        logic [DayW-1:0]   calendar_day;
        logic [HourW-1:0]  clock_hour;
        logic [MinW-1:0]   clock_minute;
        logic [SecW-1:0]   clock_second;
    } ucc_item_t;

    // One result transaction.
    typedef struct packed {
        logic [EpochW-1:0] epoch_out;
        logic [YearW-1:0]  year_out;
        logic [MonthW-1:0] month_out;
        logic [DayW-1:0]   day_out;
        logic [HourW-1:0]  hour_out;
        logic [MinW-1:0]   minute_out;
        logic [SecW-1:0]   second_out;
    } ucc_result_t;

    // Shared adder / subtractor request and response.
    typedef struct packed {
        logic [EpochW-1:0] a;
        logic [EpochW-1:0] b;
        logic              sub;
    } ucc_alu_req_t;

    typedef struct packed {
        logic [EpochW-1:0] result;
        logic              carry;
    } ucc_alu_rsp_t;

    // Gregorian leap rule. The remainder by 25 comes from a reciprocal
    // multiply, exact for every 12-bit year.
    function automatic logic leap_year(input logic [YearW-1:0] y);
        logic [22:0]      prod;
        logic [7:0]       quot;
        logic [YearW-1:0] rem25;
        logic             by4;
        logic             by16;
        logic             by25;
        prod  = 23'(y) * 23'd1311;
        quot  = prod[22:15];
        rem25 = y - (12'(quot) * 12'd25);
        by4   = (y[1:0] == 2'd0);
        by16  = (y[3:0] == 4'd0);
        by25  = (rem25 == 12'd0);
        return by4 && (!by25 || by16);
    endfunction

    // Length of a year in days.
    function automatic logic [8:0] year_length(input logic leap);
        return leap ? DAYS_LEAP : DAYS_COMMON;
    endfunction

    // Length of a year in seconds.
    function automatic logic [EpochW-1:0] year_seconds(input logic leap);
        return leap ? SECS_PER_LEAP_YEAR : SECS_PER_COMMON_YEAR;
    endfunction

    // Length of a month in days, February by the given leap flag.
    function automatic logic [4:0] month_length(input logic [MonthW-1:0] m,
                                                input logic leap);
        if (m == MONTH_FEB) begin
            return leap ? FEB_LEAP : FEB_COMMON;
        end
        return MONTH_DAYS[m];
    endfunction

    // Length of a month in seconds; a month of no days takes no seconds.
    function automatic logic [EpochW-1:0] month_seconds(input logic [MonthW-1:0] m,
                                                        input logic leap);
        logic [4:0]        len;
        logic [EpochW-1:0] secs;
        len = month_length(m, leap);
        unique case (len)
            5'd28:   secs = 32'd2419200;
            5'd29:   secs = 32'd2505600;
            5'd30:   secs = 32'd2592000;
            5'd31:   secs = 32'd2678400;
            default: secs = '0;
        endcase
        return secs;
    endfunction

endpackage

// ===== hw/rtl/ucc_alu.sv =====
// ----------------------------------------------------------------------------
// ucc_alu: shared 32-bit adder / subtractor
// The single adder / subtractor of the converter. It serves the year, month,
// day, hour and minute loops, the day steps and the final accumulation in turn.
// ----------------------------------------------------------------------------
module ucc_alu
    import ucc_pkg::*;
(
    input  ucc_alu_req_t req,
    output ucc_alu_rsp_t rsp
);

    logic [EpochW:0] sum_ext;

    // Add or subtract; the top bit is the carry, or the borrow when subtracting.
    always_comb begin
        if (req.sub) begin
            sum_ext = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            sum_ext = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.result = sum_ext[EpochW-1:0];
        rsp.carry  = sum_ext[EpochW];
    end

endmodule

// ===== hw/rtl/ucc_seq.sv =====
// ----------------------------------------------------------------------------
// ucc_seq: conversion sequencer
// Holds one transaction and steps it through the year, month, day, hour and
// minute subtraction loops, or the year, month and day sums and the weighted
// accumulation: one shared-unit operation per cycle, none in multiply or done.
// ----------------------------------------------------------------------------
module ucc_seq
    import ucc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  ucc_item_t    item,
    output logic         idle,
    output logic         res_valid,
    input  logic         res_ready,
    output ucc_result_t  result,
    output ucc_alu_req_t alu_req,
    input  ucc_alu_rsp_t alu_rsp
);

    // The widest weight of the epoch sum, seconds per day, fits this width.
    localparam int WeightW = 17;
    localparam int MulW    = EpochW + WeightW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR0,
        ST_MONTH0,
        ST_DAY0,
        ST_HOUR0,
        ST_MIN0,
        ST_YEAR1,
        ST_MONTH1,
        ST_DAY_DEC,
        ST_DAY_ADD,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TERM_DAYS,
        TERM_HOURS,
        TERM_MINS,
        TERM_SECS
    } term_t;

    state_t            state_reg,  state_next;
    term_t             term_reg,   term_next;
    logic [EpochW-1:0] rem_reg,    rem_next;
    logic [EpochW-1:0] days_reg,   days_next;
    logic [EpochW-1:0] prod_reg,   prod_next;
    logic [EpochW-1:0] acc_reg,    acc_next;
    logic [YearW-1:0]  year_reg,   year_next;
    logic [MonthW-1:0] month_reg,  month_next;
    logic [DayW-1:0]   mday_reg,   mday_next;
    logic [HourW-1:0]  hour_reg,   hour_next;
    logic [MinW-1:0]   minute_reg, minute_next;
    logic [SecW-1:0]   second_reg, second_next;
    ucc_item_t         item_reg,   item_next;

    logic              cur_leap;
    logic [EpochW-1:0] year_len;
    logic [EpochW-1:0] month_len;
    logic [EpochW-1:0] year_secs;
    logic [EpochW-1:0] month_secs;
    logic [EpochW-1:0] mul_a;
    logic [WeightW-1:0] mul_b;
    logic [MulW-1:0]   prod_full;

    // Calendar lengths for the year under consideration.
    assign cur_leap   = leap_year(year_reg);
    assign year_len   = EpochW'(year_length(cur_leap));
    assign month_len  = EpochW'(month_length(month_reg, cur_leap));
    assign year_secs  = year_seconds(cur_leap);
    assign month_secs = month_seconds(month_reg, cur_leap);

    // Operands of the weighting multiply for the epoch sum.
    always_comb begin
        unique case (term_reg)
            TERM_DAYS: begin
                mul_a = days_reg;
                mul_b = WeightW'(SECS_PER_DAY);
            end
            TERM_HOURS: begin
                mul_a = EpochW'(item_reg.clock_hour);
                mul_b = WeightW'(SECS_PER_HOUR);
            end
            TERM_MINS: begin
                mul_a = EpochW'(item_reg.clock_minute);
                mul_b = WeightW'(SECS_PER_MIN);
            end
            TERM_SECS: begin
                mul_a = EpochW'(item_reg.clock_second);
                mul_b = WeightW'(1);
            end
            default: begin
                mul_a = days_reg;
                mul_b = WeightW'(1);
            end
        endcase
    end

    assign prod_full = MulW'(mul_a) * MulW'(mul_b);

    // Request to the shared unit, chosen by the current step.
    always_comb begin
        alu_req.a   = days_reg;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            ST_YEAR0: begin
                alu_req.a   = rem_reg;
                alu_req.b   = year_secs;
                alu_req.sub = 1'b1;
            end
            ST_MONTH0: begin
                alu_req.a   = rem_reg;
                alu_req.b   = month_secs;
                alu_req.sub = 1'b1;
            end
            ST_DAY0: begin
                alu_req.a   = rem_reg;
                alu_req.b   = SECS_PER_DAY;
                alu_req.sub = 1'b1;
            end
            ST_HOUR0: begin
                alu_req.a   = rem_reg;
                alu_req.b   = SECS_PER_HOUR;
                alu_req.sub = 1'b1;
            end
            ST_MIN0: begin
                alu_req.a   = rem_reg;
                alu_req.b   = SECS_PER_MIN;
                alu_req.sub = 1'b1;
            end
            ST_YEAR1: begin
                alu_req.b = year_len;
            end
            ST_MONTH1: begin
                alu_req.b = month_len;
            end
            ST_DAY_DEC: begin
                alu_req.b   = EpochW'(1);
                alu_req.sub = 1'b1;
            end
            ST_DAY_ADD: begin
                alu_req.b = EpochW'(item_reg.calendar_day);
            end
            ST_ACC: begin
                alu_req.a = acc_reg;
                alu_req.b = prod_reg;
            end
            default: begin
                alu_req.b = '0;
            end
        endcase
    end

    // Sequencer next-state and datapath updates.
    always_comb begin
        state_next  = state_reg;
        term_next   = term_reg;
        rem_next    = rem_reg;
        days_next   = days_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        mday_next   = mday_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        item_next   = item_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    item_next = item;
                    if (item.mode == MODE_TO_CALENDAR) begin
                        rem_next    = item.epoch_seconds;
                        year_next   = EPOCH_YEAR;
                        mday_next   = '0;
                        hour_next   = '0;
                        minute_next = '0;
                        state_next  = ST_YEAR0;
                    end else begin
                        year_next  = EPOCH_YEAR;
                        days_next  = '0;
                        state_next = ST_YEAR1;
                    end
                end
            end

            // Take off whole years while the seconds cover one.
            ST_YEAR0: begin
                if (alu_rsp.carry) begin
                    month_next = MONTH_JAN;
                    state_next = ST_MONTH0;
                end else begin
                    rem_next  = alu_rsp.result;
                    year_next = year_reg + YearW'(1);
                end
            end

            // Take off whole months; December takes what is left.
            ST_MONTH0: begin
                if (month_reg == MONTH_DEC || alu_rsp.carry) begin
                    state_next = ST_DAY0;
                end else begin
                    rem_next   = alu_rsp.result;
                    month_next = month_reg + MonthW'(1);
                end
            end

            // Count whole days, then hours, then minutes; seconds are left over.
            ST_DAY0: begin
                if (alu_rsp.carry) begin
                    state_next = ST_HOUR0;
                end else begin
                    rem_next  = alu_rsp.result;
                    mday_next = mday_reg + DayW'(1);
                end
            end

            ST_HOUR0: begin
                if (alu_rsp.carry) begin
                    state_next = ST_MIN0;
                end else begin
                    rem_next  = alu_rsp.result;
                    hour_next = hour_reg + HourW'(1);
                end
            end

            ST_MIN0: begin
                if (alu_rsp.carry) begin
                    second_next = rem_reg[SecW-1:0];
                    state_next  = ST_DONE;
                end else begin
                    rem_next    = alu_rsp.result;
                    minute_next = minute_reg + MinW'(1);
                end
            end

            // Sum the days of the years before the given one.
            ST_YEAR1: begin
                if (year_reg < item_reg.calendar_year) begin
                    days_next = alu_rsp.result;
                    year_next = year_reg + YearW'(1);
                end else begin
                    year_next  = item_reg.calendar_year;
                    month_next = MONTH_JAN;
                    state_next = ST_MONTH1;
                end
            end

            // Sum the days of the earlier months of that year.
            ST_MONTH1: begin
                if (month_reg < item_reg.calendar_month) begin
                    days_next  = alu_rsp.result;
                    month_next = month_reg + MonthW'(1);
                end else begin
                    state_next = ST_DAY_DEC;
                end
            end

            ST_DAY_DEC: begin
                days_next  = alu_rsp.result;
                state_next = ST_DAY_ADD;
            end

            ST_DAY_ADD: begin
                days_next  = alu_rsp.result;
                acc_next   = '0;
                term_next  = TERM_DAYS;
                state_next = ST_MUL;
            end

            // Weight one term, then add it in.
            ST_MUL: begin
                prod_next  = prod_full[EpochW-1:0];
                state_next = ST_ACC;
            end

            ST_ACC: begin
                acc_next = alu_rsp.result;
                unique case (term_reg)
                    TERM_DAYS: begin
                        term_next  = TERM_HOURS;
                        state_next = ST_MUL;
                    end
                    TERM_HOURS: begin
                        term_next  = TERM_MINS;
                        state_next = ST_MUL;
                    end
                    TERM_MINS: begin
                        term_next  = TERM_SECS;
                        state_next = ST_MUL;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and datapath registers; only control state is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        term_reg   <= term_next;
        rem_reg    <= rem_next;
        days_reg   <= days_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        mday_reg   <= mday_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        item_reg   <= item_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    // Computed fields for the chosen direction, the others echoed.
    always_comb begin
        if (item_reg.mode == MODE_TO_CALENDAR) begin
            result.epoch_out  = item_reg.epoch_seconds;
            result.year_out   = year_reg;
            result.month_out  = month_reg;
            result.day_out    = mday_reg + DayW'(1);
            result.hour_out   = hour_reg;
            result.minute_out = minute_reg;
            result.second_out = second_reg;
        end else begin
            result.epoch_out  = acc_reg;
            result.year_out   = item_reg.calendar_year;
            result.month_out  = item_reg.calendar_month;
            result.day_out    = item_reg.calendar_day;
            result.hour_out   = item_reg.clock_hour;
            result.minute_out = item_reg.clock_minute;
            result.second_out = item_reg.clock_second;
        end
    end

endmodule

// ===== hw/rtl/unix_epoch_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// unix_epoch_calendar_converter: Unix seconds to and from Gregorian calendar
// Converts 32-bit Unix seconds to a calendar date and time of day (tuser 0),
// or a calendar date and time to Unix seconds wrapped modulo 2^32 (tuser 1);
// the fields a direction does not compute are echoed. One transaction is
// worked on at a time and the input is not ready while it is in progress.
// Seconds to calendar takes off whole years, months, days, hours and minutes
// by repeated subtraction, in five loops one after another. Calendar to
// seconds sums the days of each year from 1970 up to the given year and of
// each earlier month, adds the day of the month less one, and then forms the
// weighted time sum, whose weights come from a small multiplier. Every
// addition, subtraction and comparison of the running totals goes through
// one shared adder / subtractor. The result reaches the output through an
// output register, where a finished result waits, so the next transaction
// may be accepted while it is still being taken.
// ----------------------------------------------------------------------------
module unix_epoch_calendar_converter
    import ucc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    // epoch_seconds[31:0], calendar_year[43:32], calendar_month[47:44],
    // calendar_day[52:48], clock_hour[57:53], clock_minute[63:58],
    // clock_second[69:64], zero fill above
    input  logic [TdataW-1:0] s_tdata,
    // mode[0]
    input  logic              s_tuser,

    output logic              m_tvalid,
    input  logic              m_tready,
    // epoch_out[31:0], year_out[43:32], month_out[47:44], day_out[52:48],
    // hour_out[57:53], minute_out[63:58], second_out[69:64], zero fill above
    output logic [TdataW-1:0] m_tdata
);

    ucc_item_t    item;
    ucc_result_t  result;
    ucc_alu_req_t alu_req;
    ucc_alu_rsp_t alu_rsp;
    logic         seq_idle;
    logic         res_valid;
    logic         res_ready;
    logic         start;

    logic              out_valid_reg, out_valid_next;
    logic [TdataW-1:0] out_data_reg,  out_data_next;

    // Unpack the input transaction.
    always_comb begin
        item.mode           = s_tuser;
        item.epoch_seconds  = s_tdata[31:0];
        item.calendar_year  = s_tdata[43:32];
        item.calendar_month = s_tdata[47:44];
        item.calendar_day   = s_tdata[52:48];
        item.clock_hour     = s_tdata[57:53];
        item.clock_minute   = s_tdata[63:58];
        item.clock_second   = s_tdata[69:64];
    end

    assign s_tready = seq_idle;
    assign start    = s_tvalid && s_tready;

    ucc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ucc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    // The output register takes a result when it is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = {{(TdataW - FieldBits){1'b0}},
                              result.second_out, result.minute_out,
                              result.hour_out, result.day_out,
                              result.month_out, result.year_out,
                              result.epoch_out};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
